[hdl/maximal_cluster_table_defines.svh]
// Assertion macros for the cluster table checker.
`ifndef MAXIMAL_CLUSTER_TABLE_DEFINES_SVH
`define MAXIMAL_CLUSTER_TABLE_DEFINES_SVH

// Clocked assertion, disabled while reset is applied.
`define MCT_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Implication checked on every rising clock edge.
`define MCT_ASSERT_IMPL(label, ante, cons, msg) \
	`MCT_ASSERT(label, (ante) |-> (cons), msg)

`endif

[hdl/mct_pkg.sv]
// Shared types and constants of the cluster table.
package mct_pkg;

	localparam int NUM_SLOTS_DEF  = 16;
	localparam int MAX_POINTS_DEF = 32;

	localparam logic [1:0] MODE_PUSH  = 2'd0;
	localparam logic [1:0] MODE_CLEAR = 2'd1;
	localparam logic [1:0] MODE_READ  = 2'd2;
	localparam logic [1:0] MODE_NONE  = 2'd3;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_LONG  = 2'd2;
	localparam logic [1:0] ST_ORDER = 2'd3;

	typedef struct packed {
		logic [1:0]  mode;
		logic [31:0] point_id;
		logic [31:0] start_time;
		logic        last;
		logic [3:0]  read_slot;
		logic [4:0]  read_pos;
	} req_t;

	typedef struct packed {
		logic        inserted;
		logic [4:0]  evicted_count;
		logic [4:0]  occupied;
		logic [1:0]  status;
		logic        slot_valid;
		logic [5:0]  slot_size;
		logic [31:0] slot_start;
		logic [31:0] slot_point;
	} rsp_t;

endpackage

[hdl/mct_if.sv]
// Channel interfaces: request stream, result stream, config write.
interface mct_req_if;
	import mct_pkg::*;
	logic valid;
	logic ready;
	req_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface mct_rsp_if;
	import mct_pkg::*;
	logic valid;
	logic ready;
	rsp_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface mct_cfg_if;
	logic valid;
	logic ready;
	logic data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[hdl/maximal_cluster_table.sv]
// Cluster table: maximal-set maintenance with sorted-merge subset checks.
// Push without last: appends the point, no result. Read: S_READ, S_RDONE, load. Clear: load.
// Push with last: walk each slot; for a valid slot run the sorted merge (steps <= S+N)
// and decide drop or evict, then free-slot search, copy of the new points, and load;
// one merge compare unit and one point-memory read port serve all of it. Results leave via a register.
// Reset (arst_n low): slot valid bits, counters and sequencer cleared; point memories undefined.
module maximal_cluster_table #(
	parameter int NUM_SLOTS  = mct_pkg::NUM_SLOTS_DEF,
	parameter int MAX_POINTS = mct_pkg::MAX_POINTS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	mct_req_if.sink   req,
	mct_rsp_if.source rsp,
	mct_cfg_if.sink   cfg
);
	import mct_pkg::*;

	localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int PW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int CW = $clog2(MAX_POINTS + 1);
	localparam int EW = $clog2(NUM_SLOTS + 1);
	localparam int AW = $clog2(NUM_SLOTS * MAX_POINTS);
	localparam int DEPTH = NUM_SLOTS * MAX_POINTS;

	typedef enum logic [8:0] {
		S_IDLE   = 9'b000000001,
		S_WALK   = 9'b000000010,
		S_MERGE  = 9'b000000100,
		S_DECIDE = 9'b000001000,
		S_FIND   = 9'b000010000,
		S_COPY   = 9'b000100000,
		S_READ   = 9'b001000000,
		S_RDONE  = 9'b010000000,
		S_LOAD   = 9'b100000000
	} state_t;

	state_t state_q;

	// memories
	logic [31:0] pt_mem [DEPTH];
	logic [31:0] np_mem [MAX_POINTS];
	logic [31:0] pt_rd_q, np_rd_q;
	logic [AW-1:0] pt_raddr, pt_waddr;
	logic [PW-1:0] np_raddr;

	// per-slot flops
	logic [NUM_SLOTS-1:0] valid_q;
	logic [CW-1:0] size_q  [NUM_SLOTS];
	logic [31:0]   start_q [NUM_SLOTS];

	// partial cluster
	logic [CW-1:0] nsize_q;
	logic [31:0]   nstart_q;
	logic [1:0]    nerr_q;
	logic [31:0]   last_pid_q;

	logic          cmp_times_q;
	logic [EW-1:0] occ_q;

	// walk / merge counters
	logic [SW-1:0] cur_q;
	logic [CW-1:0] i_q, j_q, c_q, k_q;
	logic          phase_q;
	logic          cpy_s1;
	logic [PW-1:0] kk_s1;

	// result under construction
	logic          is_push_q;
	logic          ins_q;
	logic [EW-1:0] evict_q;
	logic [1:0]    status_q;
	logic [3:0]    rslot_q;
	logic [4:0]    rpos_q;
	logic          rd_ok_q;
	logic          rd_valid_q;
	logic [5:0]    rd_size_q;
	logic [31:0]   rd_start_q;
	logic [31:0]   rd_point_q;

	logic out_valid_q;
	rsp_t out_q;

	function automatic logic [AW-1:0] slot_addr(input logic [SW-1:0] s, input logic [PW-1:0] p);
		slot_addr = AW'(AW'(s) * AW'(MAX_POINTS) + AW'(p));
	endfunction

	function automatic logic [4:0] sat31(input logic [EW-1:0] v);
		sat31 = (32'(v) > 32'd31) ? 5'd31 : 5'(v);
	endfunction

	assign req.ready = (state_q == S_IDLE);
	assign cfg.ready = 1'b1;
	assign rsp.valid = out_valid_q;
	assign rsp.data  = out_q;

	logic accept;
	assign accept = req.valid && req.ready;

	// push decode
	logic [1:0] push_err;
	always_comb begin
		push_err = nerr_q;
		if (nerr_q == ST_OK) begin
			if (32'(nsize_q) >= 32'(MAX_POINTS))
				push_err = ST_LONG;
			else if (nsize_q != '0 && req.data.point_id <= last_pid_q)
				push_err = ST_ORDER;
		end
	end

	logic [SW-1:0] rd_idx;
	logic          rd_in_range;
	assign rd_idx      = SW'(req.data.read_slot);
	assign rd_in_range = (32'(req.data.read_slot) < 32'(NUM_SLOTS));

	// merge / decision
	logic [CW-1:0] cur_size;
	logic [31:0]   cur_start;
	logic          merge_done, drop, evict;
	assign cur_size   = size_q[cur_q];
	assign cur_start  = start_q[cur_q];
	assign merge_done = (i_q == cur_size) || (j_q == nsize_q);

	always_comb begin
		drop  = 1'b0;
		evict = 1'b0;
		if (cmp_times_q) begin
			if (c_q == nsize_q) begin
				if (cur_start <= nstart_q) drop = 1'b1;
				else if (cur_size == c_q) evict = 1'b1;
			end else if (cur_size == c_q) begin
				if (!(cur_start < nstart_q)) evict = 1'b1;
			end
		end else begin
			if (c_q == nsize_q) drop = 1'b1;
			else if (cur_size == c_q) evict = 1'b1;
		end
	end

	logic last_slot;
	assign last_slot = (32'(cur_q) == 32'(NUM_SLOTS - 1));

	// memory ports
	always_comb begin
		pt_raddr = slot_addr(SW'(rslot_q), PW'(rpos_q));
		np_raddr = PW'(k_q);
		if (state_q == S_MERGE) begin
			pt_raddr = slot_addr(cur_q, PW'(i_q));
			np_raddr = PW'(j_q);
		end
	end
	assign pt_waddr = slot_addr(cur_q, kk_s1);

	always_ff @(posedge clk) begin
		pt_rd_q <= pt_mem[pt_raddr];
		np_rd_q <= np_mem[np_raddr];
		if (state_q == S_COPY && cpy_s1)
			pt_mem[pt_waddr] <= np_rd_q;
		if (accept && req.data.mode == MODE_PUSH && push_err == ST_OK)
			np_mem[PW'(nsize_q)] <= req.data.point_id;
	end

	// slot payload
	always_ff @(posedge clk) begin
		if (state_q == S_FIND && !valid_q[cur_q]) begin
			size_q[cur_q]  <= nsize_q;
			start_q[cur_q] <= nstart_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			valid_q     <= '0;
			nsize_q     <= '0;
			nstart_q    <= '0;
			nerr_q      <= ST_OK;
			last_pid_q  <= '0;
			cmp_times_q <= 1'b1;
			occ_q       <= '0;
			cur_q       <= '0;
			i_q         <= '0;
			j_q         <= '0;
			c_q         <= '0;
			k_q         <= '0;
			phase_q     <= 1'b0;
			cpy_s1      <= 1'b0;
			kk_s1       <= '0;
			is_push_q   <= 1'b0;
			ins_q       <= 1'b0;
			evict_q     <= '0;
			status_q    <= ST_OK;
			rslot_q     <= '0;
			rpos_q      <= '0;
			rd_ok_q     <= 1'b0;
			rd_valid_q  <= 1'b0;
			rd_size_q   <= '0;
			rd_start_q  <= '0;
			rd_point_q  <= '0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			if (cfg.valid && cfg.ready)
				cmp_times_q <= cfg.data;
			// the load state refills the register itself
			if (out_valid_q && rsp.ready && state_q != S_LOAD)
				out_valid_q <= 1'b0;

			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						ins_q      <= 1'b0;
						evict_q    <= '0;
						status_q   <= ST_OK;
						rd_valid_q <= 1'b0;
						rd_size_q  <= '0;
						rd_start_q <= '0;
						rd_point_q <= '0;
						is_push_q  <= 1'b0;
						unique case (req.data.mode)
							MODE_PUSH: begin
								if (nsize_q == '0 && nerr_q == ST_OK)
									nstart_q <= req.data.start_time;
								nerr_q <= push_err;
								if (push_err == ST_OK) begin
									nsize_q    <= nsize_q + 1'b1;
									last_pid_q <= req.data.point_id;
								end
								if (req.data.last) begin
									is_push_q <= 1'b1;
									if (push_err != ST_OK) begin
										status_q <= push_err;
										state_q  <= S_LOAD;
									end else begin
										cur_q   <= '0;
										state_q <= S_WALK;
									end
								end
							end
							MODE_CLEAR: begin
								valid_q  <= '0;
								occ_q    <= '0;
								nsize_q  <= '0;
								nerr_q   <= ST_OK;
								nstart_q <= '0;
								state_q  <= S_LOAD;
							end
							MODE_READ: begin
								rslot_q <= req.data.read_slot;
								rpos_q  <= req.data.read_pos;
								rd_ok_q <= rd_in_range && valid_q[rd_idx];
								state_q <= S_READ;
							end
							default: ;
						endcase
					end
				end
				S_WALK: begin
					if (valid_q[cur_q]) begin
						i_q     <= '0;
						j_q     <= '0;
						c_q     <= '0;
						phase_q <= 1'b0;
						state_q <= S_MERGE;
					end else if (last_slot) begin
						cur_q   <= '0;
						state_q <= S_FIND;
					end else begin
						cur_q <= cur_q + 1'b1;
					end
				end
				S_MERGE: begin
					if (!phase_q) begin
						if (merge_done) state_q <= S_DECIDE;
						else phase_q <= 1'b1;
					end else begin
						phase_q <= 1'b0;
						if (pt_rd_q < np_rd_q) begin
							i_q <= i_q + 1'b1;
						end else if (np_rd_q < pt_rd_q) begin
							j_q <= j_q + 1'b1;
						end else begin
							i_q <= i_q + 1'b1;
							j_q <= j_q + 1'b1;
							c_q <= c_q + 1'b1;
						end
					end
				end
				S_DECIDE: begin
					if (drop) begin
						state_q <= S_LOAD;
					end else begin
						if (evict) begin
							valid_q[cur_q] <= 1'b0;
							evict_q        <= evict_q + 1'b1;
							occ_q          <= occ_q - 1'b1;
						end
						if (last_slot) begin
							cur_q   <= '0;
							state_q <= S_FIND;
						end else begin
							cur_q   <= cur_q + 1'b1;
							state_q <= S_WALK;
						end
					end
				end
				S_FIND: begin
					if (!valid_q[cur_q]) begin
						k_q     <= '0;
						cpy_s1  <= 1'b0;
						state_q <= S_COPY;
					end else if (last_slot) begin
						status_q <= ST_FULL;
						state_q  <= S_LOAD;
					end else begin
						cur_q <= cur_q + 1'b1;
					end
				end
				S_COPY: begin
					// read new_points[k], write it in the following cycle
					cpy_s1 <= (k_q != nsize_q);
					kk_s1  <= PW'(k_q);
					if (k_q != nsize_q) begin
						k_q <= k_q + 1'b1;
					end else if (!cpy_s1) begin
						valid_q[cur_q] <= 1'b1;
						occ_q          <= occ_q + 1'b1;
						ins_q          <= 1'b1;
						state_q        <= S_LOAD;
					end
				end
				S_READ: begin
					state_q <= S_RDONE;
				end
				S_RDONE: begin
					if (rd_ok_q) begin
						rd_valid_q <= 1'b1;
						rd_size_q  <= (32'(size_q[SW'(rslot_q)]) > 32'd63) ? 6'd63
							: 6'(size_q[SW'(rslot_q)]);
						rd_start_q <= start_q[SW'(rslot_q)];
						if (32'(rpos_q) < 32'(size_q[SW'(rslot_q)]))
							rd_point_q <= pt_rd_q;
					end
					state_q <= S_LOAD;
				end
				S_LOAD: begin
					if (!out_valid_q || rsp.ready) begin
						out_q.inserted      <= ins_q;
						out_q.evicted_count <= sat31(evict_q);
						out_q.occupied      <= sat31(occ_q);
						out_q.status        <= status_q;
						out_q.slot_valid    <= rd_valid_q;
						out_q.slot_size     <= rd_size_q;
						out_q.slot_start    <= rd_start_q;
						out_q.slot_point    <= rd_point_q;
						out_valid_q         <= 1'b1;
						if (is_push_q) begin
							// partial cluster is consumed by its last point
							nsize_q  <= '0;
							nerr_q   <= ST_OK;
							nstart_q <= '0;
						end
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

[hdl/mct_checker.sv]
// Port-level checker for the cluster table, bound into maximal_cluster_table.
`include "maximal_cluster_table_defines.svh"

module mct_checker #(
	parameter int NUM_SLOTS = mct_pkg::NUM_SLOTS_DEF
) (
	input logic         clk,
	input logic         arst_n,
	input logic         rsp_valid,
	input logic         rsp_ready,
	input mct_pkg::rsp_t rsp_data
);
	import mct_pkg::*;

	`MCT_ASSERT_IMPL(a_rsp_hold, rsp_valid && !rsp_ready, ##1 rsp_valid && $stable(rsp_data), "result dropped or changed while stalled")
	`MCT_ASSERT_IMPL(a_occ_range, rsp_valid, 32'(rsp_data.occupied) <= NUM_SLOTS, "occupied exceeds slot count")
	`MCT_ASSERT_IMPL(a_ins_ok, rsp_valid && rsp_data.inserted, rsp_data.status == ST_OK, "insert with error status")
	`MCT_ASSERT_IMPL(a_read_clean, rsp_valid && rsp_data.slot_valid, !rsp_data.inserted && rsp_data.evicted_count == 5'd0 && rsp_data.status == ST_OK, "read result carries insert fields")

endmodule

bind maximal_cluster_table mct_checker #(.NUM_SLOTS(NUM_SLOTS)) u_mct_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.rsp_data  (rsp.data)
);
